/* src/deq_pkg.sv */
package deq_pkg;

   localparam int unsigned WORD_WIDTH   = 32;
   localparam int unsigned KIND_WIDTH   = 3;
   localparam int unsigned COUNT_WIDTH  = 5;
   localparam int unsigned STATUS_WIDTH = 2;

   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_POP_BACK   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_PEEK       = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd2;

   // Front and back words read as minus one when nothing is held.
   localparam logic signed [WORD_WIDTH-1:0] NONE_WORD = -32'sd1;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]        kind;
      logic signed [WORD_WIDTH-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] front_value;
      logic signed [WORD_WIDTH-1:0] back_value;
      logic [COUNT_WIDTH-1:0]       entry_count;
      logic                         is_empty;
      logic [STATUS_WIDTH-1:0]      status;
   } rsp_payload_type;

endpackage

/* src/deq_channels.sv */
interface deq_req_if
   import deq_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface deq_rsp_if
   import deq_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* src/double_ended_queue_core.sv */
// Channel    Direction  Handshake          Payload
// req_chan   in         valid / ready      kind, value
// rsp_chan   out        valid / ready      front_value, back_value, entry_count,
//                                          is_empty, status
//
// Pushes, peeks, ignored pops and a pop of the last word load the result register
// at the request transfer, so the result is offered on the next cycle. A pop that
// leaves one or more words first reads the new end word from the ring store, which
// holds the request side off in the read state until the result register is loaded.
// The result register lets a new request in while the last result is taken in the
// same cycle. Reset is synchronous and empties the queue; the ring store itself is
// not cleared.
module double_ended_queue_core
   import deq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   deq_req_if.sink     req_chan,
   deq_rsp_if.source   rsp_chan
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [IW-1:0]                front_idx_ff, front_idx_in;
   logic [IW-1:0]                back_idx_ff, back_idx_in;
   logic [CW-1:0]                count_ff, count_in;
   logic signed [WORD_WIDTH-1:0] front_word_ff, front_word_in;
   logic signed [WORD_WIDTH-1:0] back_word_ff, back_word_in;
   logic                         from_front_ff, from_front_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_payload_type              rsp_data_ff, rsp_data_in;

   logic signed [WORD_WIDTH-1:0] ring_store [DEPTH];
   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   logic signed [WORD_WIDTH-1:0] wr_data;
   logic                         rd_en;
   logic [IW-1:0]                rd_addr;
   logic signed [WORD_WIDTH-1:0] rd_data_ff;

   logic                         rsp_free;
   logic                         accept;
   logic                         load_rsp;
   logic [STATUS_WIDTH-1:0]      status;
   logic [CW+COUNT_WIDTH-1:0]    count_ext;
   logic [IW-1:0]                front_next, front_prev, back_next, back_prev;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign front_next = (front_idx_ff == LAST_SLOT) ? '0 : front_idx_ff + 1'b1;
   assign front_prev = (front_idx_ff == '0) ? LAST_SLOT : front_idx_ff - 1'b1;
   assign back_next  = (back_idx_ff == LAST_SLOT) ? '0 : back_idx_ff + 1'b1;
   assign back_prev  = (back_idx_ff == '0) ? LAST_SLOT : back_idx_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      front_idx_in  = front_idx_ff;
      back_idx_in   = back_idx_ff;
      count_in      = count_ff;
      front_word_in = front_word_ff;
      back_word_in  = back_word_ff;
      from_front_in = from_front_ff;
      wr_en         = 1'b0;
      wr_addr       = front_idx_ff;
      wr_data       = req_chan.data.value;
      rd_en         = 1'b0;
      rd_addr       = front_next;
      load_rsp      = 1'b0;
      status        = STATUS_OK;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_rsp = 1'b1;
               case (req_chan.data.kind)
                  KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                     if (count_ff == FULL_COUNT) begin
                        status = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        wr_en         = 1'b1;
                        back_idx_in   = front_idx_ff;
                        count_in      = CW'(1);
                        front_word_in = req_chan.data.value;
                        back_word_in  = req_chan.data.value;
                     end else if (req_chan.data.kind == KIND_PUSH_FRONT) begin
                        wr_en         = 1'b1;
                        wr_addr       = front_prev;
                        front_idx_in  = front_prev;
                        count_in      = count_ff + 1'b1;
                        front_word_in = req_chan.data.value;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = back_next;
                        back_idx_in  = back_next;
                        count_in     = count_ff + 1'b1;
                        back_word_in = req_chan.data.value;
                     end
                  end
                  KIND_POP_FRONT, KIND_POP_BACK: begin
                     if (count_ff == '0) begin
                        status = STATUS_EMPTY;
                     end else if (count_ff == CW'(1)) begin
                        count_in = '0;
                     end else begin
                        // The new end word comes from the ring store next cycle.
                        load_rsp = 1'b0;
                        rd_en    = 1'b1;
                        count_in = count_ff - 1'b1;
                        state_in = ST_READ;
                        if (req_chan.data.kind == KIND_POP_FRONT) begin
                           front_idx_in  = front_next;
                           rd_addr       = front_next;
                           from_front_in = 1'b1;
                        end else begin
                           back_idx_in   = back_prev;
                           rd_addr       = back_prev;
                           from_front_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
               if (from_front_ff) begin
                  front_word_in = rd_data_ff;
               end else begin
                  back_word_in = rd_data_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign count_ext = {{COUNT_WIDTH{1'b0}}, count_in};

   always_comb begin
      rsp_data_in             = rsp_data_ff;
      rsp_valid_in            = rsp_valid_ff && !rsp_chan.ready;
      if (load_rsp) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.front_value = (count_in == '0) ? NONE_WORD : front_word_in;
         rsp_data_in.back_value  = (count_in == '0) ? NONE_WORD : back_word_in;
         rsp_data_in.entry_count = count_ext[COUNT_WIDTH-1:0];
         rsp_data_in.is_empty    = (count_in == '0);
         rsp_data_in.status      = status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_idx_ff <= '0;
         back_idx_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_idx_ff <= front_idx_in;
         back_idx_ff  <= back_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      front_word_ff <= front_word_in;
      back_word_ff  <= back_word_in;
      from_front_ff <= from_front_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ring_store[rd_addr];
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule
